// File: rtl/asr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the averaging sweep recorder.
package asr_pkg;
  localparam int unsigned MaxSignals = 8;
  localparam int unsigned MaxPoints  = 2048;
  localparam int unsigned SigW  = 3;
  localparam int unsigned PtW   = 11;
  localparam int unsigned CntW  = 12;
  localparam int unsigned SumW  = 48;
  localparam int unsigned AddrW = SigW + PtW;
  localparam int unsigned Depth = MaxSignals * MaxPoints;

  localparam logic [2:0] ActSample = 3'd0;
  localparam logic [2:0] ActTick   = 3'd1;
  localparam logic [2:0] ActStart  = 3'd2;
  localparam logic [2:0] ActStop   = 3'd3;
  localparam logic [2:0] ActErase  = 3'd4;
  localparam logic [2:0] ActRead   = 3'd5;

  localparam logic [1:0] RegNumPoints = 2'd0;
  localparam logic [1:0] RegNumAvg    = 2'd1;
  localparam logic [1:0] RegRealLim   = 2'd2;
  localparam logic [1:0] RegLiveLim   = 2'd3;

  typedef enum logic [3:0] {
    StClear, StIdle, StExec, StSumRd, StDivStart, StDivWait, StStore, StFinish,
    StReadWait, StReadData, StErase, StOut
  } state_e;

  typedef struct packed {
    logic exec;       // apply simple actions of the held item
    logic sum_add;    // accumulate held sample
    logic div_start;  // start divide of sum at div_sig
    logic store;      // write average (quotient or clamped sum) to memory, advance div_sig
    logic finish;     // bump count, check limits, clear sums
    logic halt;       // memory full: stop running, clear sums
    logic rd_capture; // capture read data
    logic clr_write;  // write zero at clear counter
    logic take;       // take input item
    logic out_load;   // load result register
  } cmd_t;

  typedef struct packed {
    logic set_done;   // sample closes a set reaching num_average
    logic full;       // stored count at num_points
    logic div_busy;
    logic last_sig;   // div_sig at final signal
    logic clr_last;   // clear counter at final entry
    logic rd_ok;
  } stat_t;
endpackage

// File: rtl/asr_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module asr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/asr_div.sv
`timescale 1ns / 1ps
// Restoring divider for the rounded average: trunc((2S+N)/(2N)), saturated to 32 bits.
module asr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [47:0]  sum_i,
  input  logic [15:0]         n_i,
  output logic                busy_o,
  output logic [31:0]         quot_o
);
  // 2S+N needs 50 bits signed; magnitude fits 50 bits
  logic [5:0]  cnt_q, cnt_d;
  logic [49:0] num_q, num_d;   // shifts into quotient
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        busy_q, busy_d;
  logic signed [49:0] dividend;
  logic [49:0] mag, qmag;
  logic [17:0] trial;
  logic [18:0] diff;
  logic signed [50:0] q_s;

  assign dividend = {sum_i[47], sum_i, 1'b0} + {34'd0, n_i};
  assign mag = dividend[49] ? (~dividend + 50'd1) : dividend;
  assign trial = {rem_q[16:0], num_q[49]};
  assign diff = {1'b0, trial} - {2'b00, den_q};

  always_comb begin
    cnt_d = cnt_q; num_d = num_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; busy_d = busy_q;
    if (start_i) begin
      num_d = mag; rem_d = '0; den_d = {n_i, 1'b0}; neg_d = dividend[49];
      cnt_d = 6'd50; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[18]) begin
        rem_d = diff[17:0];
        num_d = {num_q[48:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[48:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign qmag = num_q;
  assign q_s = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  always_comb begin
    if (q_s > 51'sd2147483647) quot_o = 32'h7fffffff;
    else if (q_s < -51'sd2147483648) quot_o = 32'h80000000;
    else quot_o = q_s[31:0];
  end
  assign busy_o = busy_q;
endmodule

// File: rtl/asr_ctrl.sv
`timescale 1ns / 1ps
// Control state machine of the averaging sweep recorder.
module asr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    action_i,
  input  logic          out_busy_i,
  input  asr_pkg::stat_t stat_i,
  output asr_pkg::cmd_t  cmd_o
);
  asr_pkg::state_e state_q, state_d;
  logic [2:0] act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= asr_pkg::StClear;
      act_q   <= asr_pkg::ActSample;
    end else begin
      state_q <= state_d;
      if (cmd_o.take) act_q <= action_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      asr_pkg::StClear:    if (stat_i.clr_last) state_d = asr_pkg::StIdle;
      asr_pkg::StIdle:     if (in_valid_i && !out_busy_i) state_d = asr_pkg::StExec;
      asr_pkg::StExec: begin
        case (act_q)
          asr_pkg::ActSample: begin
            if (stat_i.set_done) begin
              state_d = stat_i.full ? asr_pkg::StOut : asr_pkg::StDivStart;
            end else begin
              state_d = asr_pkg::StOut;
            end
          end
          asr_pkg::ActErase: state_d = asr_pkg::StErase;
          asr_pkg::ActRead:  state_d = stat_i.rd_ok ? asr_pkg::StReadWait : asr_pkg::StOut;
          default:           state_d = asr_pkg::StOut;
        endcase
      end
      asr_pkg::StDivStart: state_d = asr_pkg::StDivWait;
      asr_pkg::StDivWait:  if (!stat_i.div_busy) state_d = asr_pkg::StStore;
      asr_pkg::StStore:    state_d = stat_i.last_sig ? asr_pkg::StFinish : asr_pkg::StDivStart;
      asr_pkg::StFinish:   state_d = asr_pkg::StOut;
      asr_pkg::StReadWait: state_d = asr_pkg::StReadData;
      asr_pkg::StReadData: state_d = asr_pkg::StOut;
      asr_pkg::StErase:    if (stat_i.clr_last) state_d = asr_pkg::StOut;
      asr_pkg::StOut:      state_d = asr_pkg::StIdle;
      default:             state_d = asr_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      asr_pkg::StClear: cmd_o.clr_write = 1'b1;
      asr_pkg::StIdle: begin
        in_ready_o = !out_busy_i;
        cmd_o.take = in_valid_i && !out_busy_i;
      end
      asr_pkg::StExec: begin
        cmd_o.exec = 1'b1;
        if (act_q == asr_pkg::ActSample) begin
          cmd_o.sum_add = 1'b1;
          cmd_o.halt = stat_i.set_done && stat_i.full;
        end
      end
      asr_pkg::StDivStart: cmd_o.div_start = 1'b1;
      asr_pkg::StStore:    cmd_o.store = 1'b1;
      asr_pkg::StFinish:   cmd_o.finish = 1'b1;
      asr_pkg::StReadWait: cmd_o.rd_capture = 1'b0;
      asr_pkg::StReadData: cmd_o.rd_capture = 1'b1;
      asr_pkg::StErase:    cmd_o.clr_write = 1'b1;
      asr_pkg::StOut:      cmd_o.out_load = 1'b1;
      default:             cmd_o = '0;
    endcase
  end
endmodule

// File: rtl/asr_dp.sv
`timescale 1ns / 1ps
// Datapath: sums, counters, divider, sweep memory and result register.
module asr_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic [2:0]         action_i,
  input  logic [2:0]         signal_index_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               last_of_set_i,
  input  logic [10:0]        point_index_i,
  input  asr_pkg::cmd_t      cmd_i,
  output asr_pkg::stat_t     stat_o,
  output logic               out_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_data_o,
  output logic               acquiring_o,
  output logic [11:0]        points_acquired_o,
  output logic [31:0]        elapsed_ticks_o,
  output logic [11:0]        points_in_sweep_o,
  output logic               read_error_o
);
  localparam logic signed [47:0] SumMax = 48'sh7fffffffffff;
  localparam logic signed [47:0] SumMin = 48'sh800000000000;

  logic [11:0] npts_q;
  logic [15:0] navg_q, sets_q;
  logic [31:0] rlim_q, llim_q, ticks_q, elap_q;
  logic [11:0] cnt_q;
  logic        run_q;
  logic signed [47:0] sums_q [asr_pkg::MaxSignals];
  logic [2:0]  sig_q, dsig_q;
  logic signed [31:0] val_q;
  logic        last_q;
  logic [10:0] pt_q;
  logic [asr_pkg::AddrW-1:0] clr_q;
  logic [31:0] rdata_q;
  logic        rerr_q;
  logic        ov_q;
  logic [2:0]  act_hold_q;
  logic [15:0] sets_inc;
  logic signed [48:0] add_w;
  logic signed [47:0] add_sat;
  logic        mem_we;
  logic [asr_pkg::AddrW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_rdata, quot;
  logic        div_busy;

  assign sets_inc = sets_q + 16'd1;
  assign add_w = {sums_q[sig_q][47], sums_q[sig_q]} + {{17{val_q[31]}}, val_q};
  always_comb begin
    if (add_w > $signed({1'b0, SumMax})) add_sat = SumMax;
    else if (add_w < $signed({1'b1, SumMin})) add_sat = SumMin;
    else add_sat = add_w[47:0];
  end

  assign stat_o.set_done = run_q && last_q && (sets_inc >= navg_q);
  assign stat_o.full     = cnt_q >= npts_q;
  assign stat_o.div_busy = div_busy;
  assign stat_o.last_sig = dsig_q == 3'(asr_pkg::MaxSignals - 1);
  assign stat_o.clr_last = clr_q == asr_pkg::AddrW'(asr_pkg::Depth - 1);
  assign stat_o.rd_ok    = {1'b0, pt_q} < npts_q;

  asr_div u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_i.div_start),
    .sum_i   (sums_q[dsig_q]),
    .n_i     (sets_q),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_comb begin
    mem_we = 1'b0; mem_wdata = '0; mem_addr = {sig_q, pt_q};
    if (cmd_i.clr_write) begin
      mem_we = 1'b1; mem_addr = clr_q;
    end else if (cmd_i.store) begin
      mem_we = 1'b1;
      mem_addr = {dsig_q, cnt_q[10:0]};
      // n <= 1 stores the sum itself
      if (navg_q <= 16'd1 || sets_q <= 16'd1) begin
        if (sums_q[dsig_q] > 48'sh00007fffffff) mem_wdata = 32'h7fffffff;
        else if (sums_q[dsig_q] < -48'sh000080000000) mem_wdata = 32'h80000000;
        else mem_wdata = sums_q[dsig_q][31:0];
      end else begin
        mem_wdata = quot;
      end
    end
  end

  asr_ram #(.Width(32), .Depth(asr_pkg::Depth)) u_ram (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sig_q <= signal_index_i; val_q <= sample_value_i;
      last_q <= last_of_set_i; pt_q <= point_index_i;
    end
    if (cmd_i.rd_capture) rdata_q <= mem_rdata;
  end

  // action of the held item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) act_hold_q <= asr_pkg::ActSample;
    else if (cmd_i.take) act_hold_q <= action_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npts_q <= 12'd2048; navg_q <= 16'd1; rlim_q <= '0; llim_q <= '0;
      sets_q <= '0; cnt_q <= '0; run_q <= 1'b0; ticks_q <= '0; elap_q <= '0;
      for (int i = 0; i < asr_pkg::MaxSignals; i++) sums_q[i] <= '0;
      dsig_q <= '0; clr_q <= '0; ov_q <= 1'b0; rerr_q <= 1'b0;
      read_data_o <= '0; acquiring_o <= 1'b0; points_acquired_o <= '0;
      elapsed_ticks_o <= '0; points_in_sweep_o <= '0; read_error_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          asr_pkg::RegNumPoints:
            if (cfg_wdata_i[11:0] != 12'd0 && cfg_wdata_i[11:0] <= 12'd2048)
              npts_q <= cfg_wdata_i[11:0];
          asr_pkg::RegNumAvg: begin
            navg_q <= (cfg_wdata_i[15:0] == 16'd0) ? 16'd1 : cfg_wdata_i[15:0];
            sets_q <= '0;
          end
          asr_pkg::RegRealLim: rlim_q <= cfg_wdata_i;
          asr_pkg::RegLiveLim: llim_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_write) clr_q <= clr_q + asr_pkg::AddrW'(1);
      if (cmd_i.take) rerr_q <= 1'b0;
      if (cmd_i.exec) begin
        case (act_hold_q)
          asr_pkg::ActSample: begin
            if (cmd_i.halt) begin
              // set closes with the sweep full: nothing stored
              run_q <= 1'b0;
              for (int i = 0; i < asr_pkg::MaxSignals; i++) sums_q[i] <= '0;
              sets_q <= '0;
            end else if (cmd_i.sum_add && run_q) begin
              sums_q[sig_q] <= add_sat;
              if (last_q) sets_q <= sets_inc;
            end
          end
          asr_pkg::ActTick:  if (ticks_q != 32'hffffffff) ticks_q <= ticks_q + 32'd1;
          asr_pkg::ActStart: if (!run_q) begin run_q <= 1'b1; ticks_q <= '0; end
          asr_pkg::ActStop:  run_q <= 1'b0;
          asr_pkg::ActErase: begin
            cnt_q <= '0; elap_q <= '0; ticks_q <= '0; clr_q <= '0;
          end
          asr_pkg::ActRead:  rerr_q <= !stat_o.rd_ok;
          default: ;
        endcase
        dsig_q <= '0;
      end
      if (cmd_i.store) dsig_q <= dsig_q + 3'd1;
      if (cmd_i.finish) begin
        cnt_q <= cnt_q + 12'd1;
        elap_q <= ticks_q;
        if ((rlim_q != 0 && ticks_q >= rlim_q) || (llim_q != 0 && ticks_q >= llim_q))
          run_q <= 1'b0;
        for (int i = 0; i < asr_pkg::MaxSignals; i++) sums_q[i] <= '0;
        sets_q <= '0;
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
        read_data_o <= (act_hold_q == asr_pkg::ActRead && !rerr_q) ? rdata_q : '0;
        acquiring_o <= run_q;
        points_acquired_o <= cnt_q;
        elapsed_ticks_o <= elap_q;
        points_in_sweep_o <= npts_q;
        read_error_o <= rerr_q;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // a new item may start once the pending result is taken
  assign out_busy_o = ov_q && !out_ready_i;
  assign out_valid_o = ov_q;
endmodule

// File: rtl/averaging_sweep_recorder.sv
`timescale 1ns / 1ps
// Averaging sweep recorder: multi-signal averaging into a point sweep memory.
//
// Input channel (in_valid_i/in_ready_o) carries one action item: sample,
// tick, start, stop, erase or read. Each item gives exactly one result
// transfer on the output channel (out_valid_o/out_ready_i) with status.
// Items are handled one at a time. Most go from the input transfer through
// the execute and output states to the result register. A sample that
// closes an averaged set runs the shared 50-step divider once per signal
// unless the sweep is full. A read in range waits on the registered sweep
// RAM port. Erase sweeps the 16384-word RAM, one word per cycle.
// After reset the RAM is cleared by the same pass; no item is taken until
// it ends. Configuration writes take effect at once; the user must make
// them between items, while nothing is in flight; the block itself does
// not enforce this.
// A stalled receiver holds the result; the next item is taken in the
// cycle the result transfers.
module averaging_sweep_recorder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [2:0]         signal_index_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               last_of_set_i,
  input  logic [10:0]        point_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_data_o,
  output logic               acquiring_o,
  output logic [11:0]        points_acquired_o,
  output logic [31:0]        elapsed_ticks_o,
  output logic [11:0]        points_in_sweep_o,
  output logic               read_error_o
);
  asr_pkg::cmd_t  cmd;
  asr_pkg::stat_t stat;
  logic out_busy;

  asr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
    .out_busy_i(out_busy), .stat_i(stat), .cmd_o(cmd)
  );

  asr_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .action_i, .signal_index_i, .sample_value_i, .last_of_set_i, .point_index_i,
    .cmd_i(cmd), .stat_o(stat), .out_busy_o(out_busy),
    .out_valid_o, .out_ready_i, .read_data_o, .acquiring_o, .points_acquired_o,
    .elapsed_ticks_o, .points_in_sweep_o, .read_error_o
  );
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the averaging sweep recorder with a built-in status predictor.
module tb_top;
  import asr_pkg::*;

  localparam int unsigned WatchdogLimit = 50000;
  localparam longint SumMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;
  localparam logic [2:0] ActSpare6 = 3'd6;
  localparam logic [2:0] ActSpare7 = 3'd7;

  typedef struct {
    logic [2:0]         act;
    logic [2:0]         sig;
    logic signed [31:0] val;
    logic               last;
    logic [10:0]        pt;
  } item_t;

  typedef struct {
    logic signed [31:0] rdata;
    logic               acq;
    logic [11:0]        pts;
    logic [31:0]        elapsed;
    logic [11:0]        insweep;
    logic               rerr;
  } status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_addr_i = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         action_i = '0;
  logic [2:0]         signal_index_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic               last_of_set_i = 1'b0;
  logic [10:0]        point_index_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] read_data_o;
  logic               acquiring_o;
  logic [11:0]        points_acquired_o;
  logic [31:0]        elapsed_ticks_o;
  logic [11:0]        points_in_sweep_o;
  logic               read_error_o;

  averaging_sweep_recorder dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] sweep_img [0:Depth-1];
  longint      sig_sum [0:MaxSignals-1];
  int unsigned sets_done;
  int unsigned pts_stored;
  bit          acq_on;
  logic [31:0] ticks_run;
  logic [31:0] ticks_at_pt;
  int unsigned cfg_points;
  int unsigned cfg_avg;
  logic [31:0] cfg_real_lim;
  logic [31:0] cfg_live_lim;

  item_t   action_q[$];
  status_t status_q[$];
  int      err_cnt = 0;
  int      erase_budget = 8;
  bit      in_acc = 1'b0;
  bit      hold_armed = 1'b0;

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic status_t recorder_apply(input item_t it);
    status_t r;
    longint  t;
    longint  n;
    r = '{default: '0};
    case (it.act)
      ActSample: if (acq_on) begin
        t = sig_sum[it.sig] + longint'(it.val);
        if (t > SumMax) t = SumMax;
        if (t < SumMin) t = SumMin;
        sig_sum[it.sig] = t;
        if (it.last) begin
          sets_done = (sets_done + 1) & 32'hFFFF;
          if (sets_done >= cfg_avg) begin
            n = longint'(sets_done);
            if (pts_stored >= cfg_points) begin
              acq_on = 1'b0;
            end else begin
              for (int s = 0; s < MaxSignals; s++) begin
                if (cfg_avg <= 1 || n <= 1) t = sig_sum[s];
                else t = (2 * sig_sum[s] + n) / (2 * n);
                sweep_img[s * MaxPoints + pts_stored] = clamp32(t);
              end
              pts_stored++;
              ticks_at_pt = ticks_run;
              if (cfg_real_lim != 0 && ticks_at_pt >= cfg_real_lim) acq_on = 1'b0;
              if (cfg_live_lim != 0 && ticks_at_pt >= cfg_live_lim) acq_on = 1'b0;
            end
            for (int s = 0; s < MaxSignals; s++) sig_sum[s] = 0;
            sets_done = 0;
          end
        end
      end
      ActTick: if (ticks_run != 32'hFFFF_FFFF) ticks_run++;
      ActStart: if (!acq_on) begin
        acq_on = 1'b1;
        ticks_run = '0;
      end
      ActStop: acq_on = 1'b0;
      ActErase: begin
        for (int i = 0; i < Depth; i++) sweep_img[i] = '0;
        pts_stored = 0;
        ticks_at_pt = '0;
        ticks_run = '0;
      end
      ActRead: begin
        if (it.pt < cfg_points) r.rdata = sweep_img[it.sig * MaxPoints + it.pt];
        else r.rerr = 1'b1;
      end
      default: ;
    endcase
    r.acq = acq_on;
    r.pts = pts_stored[11:0];
    r.elapsed = ticks_at_pt;
    r.insweep = cfg_points[11:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("%0t: %s mismatch: got 0x%08h, expected 0x%08h", $realtime, field, got, exp_v);
    err_cnt++;
  endtask

  // input transfers feed the predictor, output transfers are checked in order
  always @(posedge clk_i) begin
    status_t e;
    in_acc <= in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        $display("%0t: result transfer with no item outstanding", $realtime);
        err_cnt++;
      end else begin
        e = status_q.pop_front();
        if (read_data_o !== e.rdata) report_mismatch("read_data", read_data_o, e.rdata);
        if (acquiring_o !== e.acq) report_mismatch("acquiring", acquiring_o, e.acq);
        if (points_acquired_o !== e.pts)
          report_mismatch("points_acquired", points_acquired_o, e.pts);
        if (elapsed_ticks_o !== e.elapsed)
          report_mismatch("elapsed_ticks", elapsed_ticks_o, e.elapsed);
        if (points_in_sweep_o !== e.insweep)
          report_mismatch("points_in_sweep", points_in_sweep_o, e.insweep);
        if (read_error_o !== e.rerr) report_mismatch("read_error", read_error_o, e.rerr);
      end
    end
    if (rst_ni && in_valid_i && in_ready_o)
      status_q.push_back(recorder_apply('{action_i, signal_index_i, sample_value_i,
                                          last_of_set_i, point_index_i}));
  end

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    item_t it;
    if (!(in_valid_i && !in_acc)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (action_q.size() > 0) begin
        it = action_q.pop_front();
        in_valid_i <= 1'b1;
        action_i <= it.act;
        signal_index_i <= it.sig;
        sample_value_i <= it.val;
        last_of_set_i <= it.last;
        point_index_i <= it.pt;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int hold_left = 0;
  int mode_left = 0;
  int rx_mode = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input logic [2:0] act, input logic [2:0] sig,
                           input logic [31:0] val, input logic last, input logic [10:0] pt);
    action_q.push_back('{act, sig, val, last, pt});
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegNumPoints: if (val[11:0] >= 1 && val[11:0] <= MaxPoints) cfg_points = val[11:0];
      RegNumAvg: begin
        cfg_avg = (val[15:0] == 0) ? 1 : val[15:0];
        sets_done = 0;
      end
      RegRealLim: cfg_real_lim = val;
      default: cfg_live_lim = val;
    endcase
  endtask

  task automatic wait_drained();
    while (action_q.size() != 0 || in_valid_i || status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed sample sets mixed with ticks, reads, control, erases and noise
  task automatic gen_traffic(input int count);
    int k;
    int r;
    logic [2:0] sg;
    push_item(ActStart, 0, 0, 0, 0);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        k = $urandom_range(1, MaxSignals);
        for (int j = 0; j < k; j++) begin
          sg = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'(j);
          push_item(ActSample, sg, pick_value(), j == k - 1, 11'($urandom));
          if ($urandom_range(0, 9) == 0) push_item(ActTick, 3'($urandom), $urandom, 0, 0);
        end
        n += k - 1;
      end else if (r < 66) begin
        push_item(ActTick, 3'($urandom), $urandom, $urandom_range(0, 1), 11'($urandom));
      end else if (r < 79) begin
        push_item(ActRead, 3'($urandom), $urandom, $urandom_range(0, 1),
                  ($urandom_range(0, 9) == 0) ? 11'($urandom)
                                               : 11'($urandom_range(0, cfg_points)));
      end else if (r < 84) begin
        push_item(ActStart, 0, $urandom, 0, 0);
      end else if (r < 87) begin
        push_item(ActStop, 0, $urandom, 0, 0);
      end else if (r < 89) begin
        push_item($urandom_range(0, 1) ? ActSpare6 : ActSpare7, 3'($urandom), $urandom,
                  $urandom_range(0, 1), 11'($urandom));
      end else if (r < 90 && erase_budget > 0) begin
        erase_budget--;
        push_item(ActErase, 0, 0, 0, 0);
      end else begin
        // noise, with erase turned into a tick
        k = $urandom_range(0, 7);
        if (k == ActErase) k = ActTick;
        push_item(3'(k), 3'($urandom), $urandom, $urandom_range(0, 1), 11'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) sweep_img[i] = '0;
    for (int s = 0; s < MaxSignals; s++) sig_sum[s] = 0;
    sets_done = 0;
    pts_stored = 0;
    acq_on = 1'b0;
    ticks_run = '0;
    ticks_at_pt = '0;
    cfg_points = MaxPoints;
    cfg_avg = 1;
    cfg_real_lim = '0;
    cfg_live_lim = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, ignored sample, extremes, saturation, spare actions
    push_item(ActRead, 0, 0, 0, 0);
    push_item(ActRead, 7, 0, 0, 11'h7FF);
    push_item(ActSample, 0, 32'h1234, 1, 0);
    push_item(ActStart, 0, 0, 0, 0);
    push_item(ActStart, 0, 0, 0, 0);
    push_item(ActTick, 0, 0, 0, 0);
    for (int s = 0; s < MaxSignals; s++)
      push_item(ActSample, 3'(s), s[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, s == 7, 11'h7FF);
    push_item(ActSample, 0, 32'h7FFF_FFFF, 0, 0);
    push_item(ActSample, 0, 32'h7FFF_FFFF, 0, 0);
    push_item(ActSample, 1, 32'h8000_0000, 0, 0);
    push_item(ActSample, 1, 32'h8000_0000, 1, 0);
    push_item(ActRead, 0, 0, 0, 1);
    push_item(ActRead, 1, 0, 0, 1);
    push_item(ActRead, 1, 0, 0, 0);
    push_item(ActSpare6, 7, 32'hFFFF_FFFF, 1, 11'h7FF);
    push_item(ActSpare7, 0, 0, 0, 0);
    push_item(ActStop, 0, 0, 0, 0);
    wait_drained();

    // small sweep, limits, ignored point counts
    write_reg(RegNumPoints, 32'd0);
    write_reg(RegNumPoints, 32'd4095);
    write_reg(RegNumPoints, 32'd3);
    write_reg(RegNumAvg, 32'd0);
    write_reg(RegRealLim, 32'd5);
    write_reg(RegLiveLim, 32'hFFFF_FFFF);
    push_item(ActStart, 0, 0, 0, 0);
    push_item(ActRead, 2, 0, 0, 3);
    for (int p = 0; p < 5; p++) begin
      push_item(ActTick, 0, 0, 0, 0);
      push_item(ActTick, 0, 0, 0, 0);
      push_item(ActSample, 3, 32'd100 + p, 1, 0);
      push_item(ActStart, 0, 0, 0, 0);
    end
    push_item(ActRead, 3, 0, 0, 2);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 3))
        0: write_reg(RegNumPoints, 32'd1);
        1: write_reg(RegNumPoints, 32'd2048);
        default: write_reg(RegNumPoints, $urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(RegNumAvg, 32'd1);
        1: write_reg(RegNumAvg, 32'd2);
        default: write_reg(RegNumAvg, $urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(RegRealLim, $urandom_range(1, 30));
        1: write_reg(RegRealLim, 32'hFFFF_FFFF);
        default: write_reg(RegRealLim, 32'd0);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(RegLiveLim, $urandom_range(1, 30));
        1: write_reg(RegLiveLim, $urandom);
        default: write_reg(RegLiveLim, 32'd0);
      endcase
      if (ph == 3) hold_armed = 1'b1;
      gen_traffic(160);
      wait_drained();
    end

    // largest average count: sets pile up without storing
    write_reg(RegNumAvg, 32'd65535);
    write_reg(RegNumPoints, 32'd2048);
    gen_traffic(60);
    wait_drained();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/asr_pkg.sv
rtl/asr_ram.sv
rtl/asr_div.sv
rtl/asr_ctrl.sv
rtl/asr_dp.sv
rtl/averaging_sweep_recorder.sv
tb/sv/tb_top.sv
